FILE: src/krcj_pkg.sv
// Shared types and constants for the keyed revision chain journal.
// No dependencies.
package krcj_pkg;

    localparam int DEPTH = 64;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = AW + 1;

    localparam logic [2:0] ST_OK            = 3'd0;
    localparam logic [2:0] ST_INVALID_ARG   = 3'd1;
    localparam logic [2:0] ST_INVALID_STATE = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND     = 3'd3;
    localparam logic [2:0] ST_OUT_OF_RANGE  = 3'd4;

    localparam logic [2:0] MODE_APPEND   = 3'd0;
    localparam logic [2:0] MODE_LATEST   = 3'd1;
    localparam logic [2:0] MODE_NEXT     = 3'd2;
    localparam logic [2:0] MODE_SNAPSHOT = 3'd3;
    localparam logic [2:0] MODE_PRUNE    = 3'd4;

    localparam logic [6:0] MAX_ENTRIES_RST = 7'd64;

    typedef struct packed {
        logic [31:0] kx;
        logic [31:0] kz;
        logic [31:0] world;
        logic [63:0] base;
        logic [63:0] fin;
        logic [63:0] src;
    } t_entry;

    typedef struct packed {
        logic       load_in;
        logic       clr_scan;
        logic       rd;
        logic       lat_upd;
        logic       idx_inc;
        logic       app_write;
        logic       set_status;
        logic [2:0] status;
        logic       set_snap;
        logic       fnd_load;
        logic       next_link;
        logic       prn_eval;
        logic       prn_done;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic [2:0] mode;
        logic       idx_end;
        logic       arg_bad;
        logic       base_max;
        logic       found;
        logic       base_ne_latest;
        logic       base_ge_latest;
        logic       hit_next;
        logic       expect_lt_latest;
    } t_stat;

endpackage

FILE: src/keyed_revision_chain_journal_top.sv
// Top level of the keyed revision chain journal.
// Depends on krcj_pkg, krcj_dp and krcj_ctrl.
//
// Request channel i_valid/o_ready carries one request beat; result channel
// o_valid/i_ready returns exactly one result beat per request, in order.
// Configuration channel i_cfg_valid/o_cfg_ready writes max_entries; it is
// always ready and should only be used while no request is in flight.
// Entries are scanned one at a time through the journal memory's
// single registered read port. Latest and append scan every entry, as
// does prune; next scans until its match. Snapshot follows the latest
// scan with one more scan per chain link. Rejected arguments, an unknown
// mode and next with base at all ones skip the scan.
// A new request is taken once the previous result sits in the output
// register; a stalled receiver holds that result and blocks the next one
// only when the following result is ready too.
// Reset empties the journal and sets max_entries to 64; no clearing pass.
module keyed_revision_chain_journal_top import krcj_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [6:0]         i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_mode,
    input  logic signed [31:0] i_chunk_x,
    input  logic signed [31:0] i_chunk_z,
    input  logic [31:0]        i_world_id,
    input  logic [63:0]        i_base_revision,
    input  logic [63:0]        i_final_revision,
    input  logic [63:0]        i_source_revision,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [2:0]         o_status,
    output logic               o_snapshot_needed,
    output logic [63:0]        o_latest_rev,
    output logic [31:0]        o_found_world,
    output logic [63:0]        o_found_base,
    output logic [63:0]        o_found_final,
    output logic [63:0]        o_found_source
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    krcj_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    krcj_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_data        (i_cfg_data),
        .i_mode            (i_mode),
        .i_chunk_x         (i_chunk_x),
        .i_chunk_z         (i_chunk_z),
        .i_world_id        (i_world_id),
        .i_base_revision   (i_base_revision),
        .i_final_revision  (i_final_revision),
        .i_source_revision (i_source_revision),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .o_status          (o_status),
        .o_snapshot_needed (o_snapshot_needed),
        .o_latest_rev      (o_latest_rev),
        .o_found_world     (o_found_world),
        .o_found_base      (o_found_base),
        .o_found_final     (o_found_final),
        .o_found_source    (o_found_source)
    );

endmodule

FILE: src/krcj_dp.sv
// Datapath: journal memory (ring order), scan registers, result register.
// Depends on krcj_pkg; driven by krcj_ctrl.
module krcj_dp import krcj_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic [6:0]         i_cfg_data,
    input  logic [2:0]         i_mode,
    input  logic signed [31:0] i_chunk_x,
    input  logic signed [31:0] i_chunk_z,
    input  logic [31:0]        i_world_id,
    input  logic [63:0]        i_base_revision,
    input  logic [63:0]        i_final_revision,
    input  logic [63:0]        i_source_revision,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    output logic [2:0]         o_status,
    output logic               o_snapshot_needed,
    output logic [63:0]        o_latest_rev,
    output logic [31:0]        o_found_world,
    output logic [63:0]        o_found_base,
    output logic [63:0]        o_found_final,
    output logic [63:0]        o_found_source
);

    t_entry         r_mem [DEPTH];
    t_entry         r_rdata;
    t_entry         r_in;
    logic [2:0]     r_mode;
    logic [6:0]     r_max;
    logic [AW-1:0]  r_head;
    logic [CW-1:0]  r_count;
    logic [CW-1:0]  r_idx;
    logic [CW-1:0]  r_wr;
    logic           r_found;
    logic [63:0]    r_latest;
    logic [63:0]    r_expect;
    logic [2:0]     r_status;
    logic           r_snap;
    t_entry         r_fnd;

    logic [31:0]    cap32;
    logic [CW-1:0]  cap;
    logic           evict;
    logic           hit_key;
    logic           keep;
    logic           we;
    logic [AW-1:0]  waddr;
    t_entry         wdata;
    t_entry         in_beat;

    always_comb begin
        cap32 = 32'(r_max);
        if (cap32 == 32'd0) begin
            cap32 = 32'd1;
        end else if (cap32 > 32'(DEPTH)) begin
            cap32 = 32'(DEPTH);
        end
        cap   = cap32[CW-1:0];
        evict = r_count >= cap;
    end

    assign hit_key = (r_rdata.kx == r_in.kx) && (r_rdata.kz == r_in.kz);
    assign keep    = !(hit_key && (r_rdata.fin <= r_in.base));

    always_comb begin
        we    = 1'b0;
        waddr = r_head + r_count[AW-1:0];
        wdata = r_in;
        if (i_cmd.app_write) begin
            we = 1'b1;
        end else if (i_cmd.prn_eval && keep) begin
            we    = 1'b1;
            waddr = r_head + r_wr[AW-1:0];
            wdata = r_rdata;
        end
    end

    assign in_beat = '{kx: i_chunk_x, kz: i_chunk_z, world: i_world_id,
                       base: i_base_revision, fin: i_final_revision,
                       src: i_source_revision};

    always_comb begin
        o_stat.mode             = r_mode;
        o_stat.idx_end          = r_idx >= r_count;
        o_stat.arg_bad          = (r_in.world == 32'd0) || (r_in.base == 64'd0) ||
                                  (r_in.fin <= r_in.base) || (r_in.src == 64'd0);
        o_stat.base_max         = &r_in.base;
        o_stat.found            = r_found;
        o_stat.base_ne_latest   = r_in.base != r_latest;
        o_stat.base_ge_latest   = r_in.base >= r_latest;
        o_stat.hit_next         = hit_key && (r_rdata.base == r_expect);
        o_stat.expect_lt_latest = r_expect < r_latest;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[r_head + r_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max   <= MAX_ENTRIES_RST;
            r_head  <= '0;
            r_count <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_max <= i_cfg_data;
            end
            if (i_cmd.app_write) begin
                if (evict) begin
                    r_head <= r_head + AW'(1);
                end else begin
                    r_count <= r_count + CW'(1);
                end
            end
            if (i_cmd.prn_done) begin
                r_count <= r_wr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in     <= in_beat;
            r_mode   <= i_mode;
            r_found  <= 1'b0;
            r_latest <= '0;
            r_expect <= i_base_revision;
            r_snap   <= 1'b0;
            r_fnd    <= '0;
            r_idx    <= '0;
            r_wr     <= '0;
        end
        if (i_cmd.clr_scan) begin
            r_idx <= '0;
        end
        if (i_cmd.idx_inc) begin
            r_idx <= r_idx + CW'(1);
        end
        if (i_cmd.lat_upd && hit_key && (!r_found || r_rdata.fin > r_latest)) begin
            r_latest <= r_rdata.fin;
            r_found  <= 1'b1;
        end
        if (i_cmd.next_link) begin
            r_expect <= r_rdata.fin;
            r_idx    <= '0;
        end
        if (i_cmd.prn_eval) begin
            r_idx <= r_idx + CW'(1);
            if (keep) begin
                r_wr <= r_wr + CW'(1);
            end
        end
        if (i_cmd.fnd_load) begin
            r_fnd <= r_rdata;
        end
        if (i_cmd.set_snap) begin
            r_snap <= 1'b1;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.out_load) begin
            o_status          <= r_status;
            o_snapshot_needed <= r_snap;
            o_latest_rev      <= (r_mode == MODE_LATEST) ? r_latest : 64'd0;
            o_found_world     <= r_fnd.world;
            o_found_base      <= r_fnd.base;
            o_found_final     <= r_fnd.fin;
            o_found_source    <= r_fnd.src;
        end
    end

endmodule

FILE: src/krcj_ctrl.sv
// Controller: request sequencer and output valid flag.
// Depends on krcj_pkg; commands krcj_dp.
module krcj_ctrl import krcj_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    output logic  o_valid,
    input  logic  i_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_LRD, S_LEV, S_LFIN, S_NRD, S_NEV, S_SCHK,
        S_PRD, S_PEV, S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_valid;

    assign o_ready = r_state == S_IDLE;
    assign o_valid = r_valid;

    task automatic put_status(input logic [2:0] code);
        o_cmd.set_status = 1'b1;
        o_cmd.status     = code;
    endtask

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_DEC;
                end
            end
            S_DEC: begin
                case (i_stat.mode)
                    MODE_APPEND: begin
                        if (i_stat.arg_bad) begin
                            put_status(ST_INVALID_ARG);
                            n_state = S_DONE;
                        end else begin
                            n_state = S_LRD;
                        end
                    end
                    MODE_LATEST, MODE_SNAPSHOT: n_state = S_LRD;
                    MODE_NEXT: begin
                        if (i_stat.base_max) begin
                            put_status(ST_OUT_OF_RANGE);
                            n_state = S_DONE;
                        end else begin
                            n_state = S_NRD;
                        end
                    end
                    MODE_PRUNE: n_state = S_PRD;
                    default: begin
                        put_status(ST_INVALID_ARG);
                        n_state = S_DONE;
                    end
                endcase
            end
            S_LRD: begin
                if (i_stat.idx_end) begin
                    n_state = S_LFIN;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_LEV;
                end
            end
            S_LEV: begin
                o_cmd.lat_upd = 1'b1;
                o_cmd.idx_inc = 1'b1;
                n_state       = S_LRD;
            end
            S_LFIN: begin
                n_state = S_DONE;
                if (i_stat.mode == MODE_APPEND) begin
                    if (i_stat.found && i_stat.base_ne_latest) begin
                        put_status(ST_INVALID_STATE);
                    end else begin
                        o_cmd.app_write = 1'b1;
                        put_status(ST_OK);
                    end
                end else if (i_stat.mode == MODE_LATEST) begin
                    put_status(i_stat.found ? ST_OK : ST_NOT_FOUND);
                end else begin
                    put_status(ST_OK);
                    if (i_stat.found && !i_stat.base_ge_latest) begin
                        o_cmd.clr_scan = 1'b1;
                        n_state        = S_NRD;
                    end
                end
            end
            S_NRD: begin
                if (i_stat.idx_end) begin
                    if (i_stat.mode == MODE_NEXT) begin
                        put_status(ST_NOT_FOUND);
                    end else begin
                        o_cmd.set_snap = 1'b1;
                    end
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_NEV;
                end
            end
            S_NEV: begin
                if (i_stat.hit_next) begin
                    if (i_stat.mode == MODE_NEXT) begin
                        o_cmd.fnd_load = 1'b1;
                        put_status(ST_OK);
                        n_state = S_DONE;
                    end else begin
                        o_cmd.next_link = 1'b1;
                        n_state         = S_SCHK;
                    end
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_NRD;
                end
            end
            S_SCHK: begin
                n_state = i_stat.expect_lt_latest ? S_NRD : S_DONE;
            end
            S_PRD: begin
                if (i_stat.idx_end) begin
                    o_cmd.prn_done = 1'b1;
                    put_status(ST_OK);
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_PEV;
                end
            end
            S_PEV: begin
                o_cmd.prn_eval = 1'b1;
                n_state        = S_PRD;
            end
            S_DONE: begin
                if (!r_valid || i_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

FILE: verif/krcj_checker.sv
`timescale 1ns / 100ps
// Checker for the keyed revision chain journal: tracks journal contents from accepted
// request beats, predicts each result and compares it field by field. Depends on krcj_pkg.
module krcj_checker import krcj_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    input  logic         i_cfg_ready,
    input  logic [6:0]   i_cfg_data,
    input  logic         i_valid,
    input  logic         i_ready_in,
    input  logic [2:0]   i_mode,
    input  logic [31:0]  i_kx,
    input  logic [31:0]  i_kz,
    input  logic [31:0]  i_world,
    input  logic [63:0]  i_base,
    input  logic [63:0]  i_fin,
    input  logic [63:0]  i_src,
    input  logic         i_res_valid,
    input  logic         i_res_ready,
    input  logic [2:0]   i_status,
    input  logic         i_snap,
    input  logic [63:0]  i_latest,
    input  logic [31:0]  i_fworld,
    input  logic [63:0]  i_fbase,
    input  logic [63:0]  i_ffinal,
    input  logic [63:0]  i_fsource,
    output int           o_fail_count,
    output int           o_pending
);

    typedef struct packed {
        logic [2:0]  status;
        logic        snap;
        logic [63:0] latest;
        logic [31:0] fworld;
        logic [63:0] fbase;
        logic [63:0] ffinal;
        logic [63:0] fsource;
    } t_result;

    t_entry    journal [DEPTH];
    int        n_entries;
    logic [6:0] cap_reg;
    t_result   results_due [$];

    assign o_pending = results_due.size();

    function automatic bit latest_of(input logic [31:0] kx, input logic [31:0] kz,
                                     output logic [63:0] rev);
        bit hit;
        hit = 0;
        rev = '0;
        for (int i = 0; i < n_entries; i++)
            if (journal[i].kx == kx && journal[i].kz == kz && (!hit || journal[i].fin > rev)) begin
                rev = journal[i].fin;
                hit = 1;
            end
        return hit;
    endfunction

    function automatic int first_with_base(input logic [31:0] kx, input logic [31:0] kz,
                                           input logic [63:0] base);
        for (int i = 0; i < n_entries; i++)
            if (journal[i].kx == kx && journal[i].kz == kz && journal[i].base == base)
                return i;
        return -1;
    endfunction

    function automatic void drop_entry(input int idx);
        for (int i = idx; i + 1 < n_entries; i++)
            journal[i] = journal[i + 1];
        if (n_entries > 0)
            n_entries--;
    endfunction

    function automatic t_result journal_step(input logic [2:0] mode, input logic [31:0] kx,
            input logic [31:0] kz, input logic [31:0] world, input logic [63:0] base,
            input logic [63:0] fin, input logic [63:0] src);
        t_result r;
        logic [63:0] top_rev;
        logic [63:0] link;
        int idx;
        int cap;
        int steps;
        r = '0;
        case (mode)
            MODE_APPEND: begin
                if (world == 0 || base == 0 || fin <= base || src == 0) begin
                    r.status = ST_INVALID_ARG;
                end else if (latest_of(kx, kz, top_rev) && base != top_rev) begin
                    r.status = ST_INVALID_STATE;
                end else begin
                    cap = (cap_reg == 0) ? 1 : (cap_reg > DEPTH ? DEPTH : int'(cap_reg));
                    if (n_entries >= cap)
                        drop_entry(0);
                    if (n_entries < DEPTH) begin
                        journal[n_entries] = '{kx: kx, kz: kz, world: world, base: base,
                                               fin: fin, src: src};
                        n_entries++;
                    end
                    r.status = ST_OK;
                end
            end
            MODE_LATEST: begin
                r.status = latest_of(kx, kz, top_rev) ? ST_OK : ST_NOT_FOUND;
                r.latest = top_rev;
            end
            MODE_NEXT: begin
                if (base == '1) begin
                    r.status = ST_OUT_OF_RANGE;
                end else begin
                    idx = first_with_base(kx, kz, base);
                    if (idx < 0) begin
                        r.status = ST_NOT_FOUND;
                    end else begin
                        r.status  = ST_OK;
                        r.fworld  = journal[idx].world;
                        r.fbase   = journal[idx].base;
                        r.ffinal  = journal[idx].fin;
                        r.fsource = journal[idx].src;
                    end
                end
            end
            MODE_SNAPSHOT: begin
                r.status = ST_OK;
                if (latest_of(kx, kz, top_rev) && base < top_rev) begin
                    link = base;
                    steps = 0;
                    while (link < top_rev && steps <= DEPTH) begin
                        idx = first_with_base(kx, kz, link);
                        if (idx < 0) begin
                            r.snap = 1;
                            break;
                        end
                        link = journal[idx].fin;
                        steps++;
                    end
                end
            end
            MODE_PRUNE: begin
                idx = 0;
                while (idx < n_entries) begin
                    if (journal[idx].kx == kx && journal[idx].kz == kz && journal[idx].fin <= base)
                        drop_entry(idx);
                    else
                        idx++;
                end
                r.status = ST_OK;
            end
            default: r.status = ST_INVALID_ARG;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            n_entries    = 0;
            cap_reg      = MAX_ENTRIES_RST;
            o_fail_count <= 0;
            results_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                cap_reg = i_cfg_data;
            if (i_valid && i_ready_in)
                results_due.insert(results_due.size(),
                                   journal_step(i_mode, i_kx, i_kz, i_world, i_base,
                                                i_fin, i_src));
            if (i_res_valid && i_res_ready) begin
                got = '{status: i_status, snap: i_snap, latest: i_latest, fworld: i_fworld,
                        fbase: i_fbase, ffinal: i_ffinal, fsource: i_fsource};
                if (results_due.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result beat %p", got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = results_due.pop_front();
                    if (got !== want) begin
                        if (o_fail_count < 10)
                            $display("mismatch: expected %p got %p", want, got);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

FILE: verif/keyed_revision_chain_journal_top_tb.sv
`timescale 1ns / 100ps
// Testbench top for the keyed revision chain journal: drives requests and capacity
// writes with random idling and gives the verdict. Depends on krcj_pkg and krcj_checker.
module keyed_revision_chain_journal_top_tb import krcj_pkg::*;;

    localparam int ITEMS = 1550;
    localparam int WATCHDOG = 60000;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [6:0]  cfg_data = '0;
    logic        req_valid = 0;
    logic        req_ready;
    logic [2:0]  mode = '0;
    logic [31:0] kx = '0;
    logic [31:0] kz = '0;
    logic [31:0] world = '0;
    logic [63:0] base = '0;
    logic [63:0] fin = '0;
    logic [63:0] src = '0;
    logic        res_valid;
    logic        res_ready = 0;
    logic [2:0]  status;
    logic        snap;
    logic [63:0] latest, fbase, ffinal, fsource;
    logic [31:0] fworld;
    int          fail_count;
    int          pending;
    int          quiet_cycles = 0;
    bit          calm = 0;
    logic [63:0] chain_top [4];
    logic [31:0] key_pool [4];

    always begin
        #10 clk = 1;
        #10 clk = 0;
    end

    keyed_revision_chain_journal_top dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .i_valid(req_valid), .o_ready(req_ready), .i_mode(mode),
        .i_chunk_x(kx), .i_chunk_z(kz), .i_world_id(world), .i_base_revision(base),
        .i_final_revision(fin), .i_source_revision(src),
        .o_valid(res_valid), .i_ready(res_ready), .o_status(status),
        .o_snapshot_needed(snap), .o_latest_rev(latest), .o_found_world(fworld),
        .o_found_base(fbase), .o_found_final(ffinal), .o_found_source(fsource)
    );

    krcj_checker chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .i_valid(req_valid), .i_ready_in(req_ready), .i_mode(mode), .i_kx(kx), .i_kz(kz),
        .i_world(world), .i_base(base), .i_fin(fin), .i_src(src),
        .i_res_valid(res_valid), .i_res_ready(res_ready), .i_status(status), .i_snap(snap),
        .i_latest(latest), .i_fworld(fworld), .i_fbase(fbase), .i_ffinal(ffinal),
        .i_fsource(fsource), .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge clk) begin
        if ((req_valid && req_ready) || (res_valid && res_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver stalls in bursts
    initial begin
        int n;
        forever begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, 17);
                res_ready <= 0;
                repeat (n) @(negedge clk);
            end
            res_ready <= 1;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // valid stays high after acceptance; callers that pause drop it first
    task automatic send_req(input logic [2:0] m, input logic [31:0] x, input logic [31:0] z,
            input logic [31:0] w, input logic [63:0] b, input logic [63:0] f,
            input logic [63:0] s);
        int n;
        if (!calm && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 17);
            req_valid <= 0;
            repeat (n) @(negedge clk);
        end
        req_valid <= 1;
        mode <= m; kx <= x; kz <= z; world <= w; base <= b; fin <= f; src <= s;
        do @(posedge clk); while (!req_ready);
        @(negedge clk);
    endtask

    task automatic wait_empty();
        req_valid <= 0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic drain_and_settle();
        wait_empty();
        repeat (300) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [6:0] v);
        drain_and_settle();
        cfg_valid <= 1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    // mostly well-formed chains on a few keys, with some noise
    task automatic random_req();
        int k;
        logic [63:0] step;
        k = $urandom_range(0, 3);
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7: begin
                step = $urandom_range(1, 5);
                if ($urandom_range(0, 15) == 0) step = rand64() | 1;
                if (chain_top[k] + step <= chain_top[k]) chain_top[k] = 1;
                send_req(MODE_APPEND, key_pool[k], ~key_pool[k], $urandom | 1, chain_top[k],
                         chain_top[k] + step, rand64() | 1);
                chain_top[k] = chain_top[k] + step;
            end
            8, 9: send_req(MODE_LATEST, key_pool[k], ~key_pool[k], 0, 0, 0, 0);
            10, 11: send_req(MODE_NEXT, key_pool[k], ~key_pool[k], 0,
                             chain_top[k] - $urandom_range(0, 12), 0, 0);
            12, 13: send_req(MODE_SNAPSHOT, key_pool[k], ~key_pool[k], 0,
                             chain_top[k] - $urandom_range(0, 15), 0, 0);
            14: send_req(MODE_PRUNE, key_pool[k], ~key_pool[k], 0,
                         chain_top[k] - $urandom_range(3, 20), 0, 0);
            15: send_req(MODE_APPEND, key_pool[k], ~key_pool[k], $urandom_range(0, 1) ? 0 : $urandom,
                         $urandom_range(0, 3) ? rand64() : 0, rand64(),
                         $urandom_range(0, 3) ? rand64() : 0);
            16: send_req($urandom_range(5, 7), $urandom, $urandom, $urandom, rand64(), rand64(),
                         rand64());
            default: send_req($urandom_range(0, 4), $urandom, $urandom, $urandom, rand64(),
                              rand64(), rand64());
        endcase
    endtask

    initial begin
        key_pool = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h1234_5678};
        chain_top = '{1, 1, 1, 1};
        repeat (2) @(negedge clk);
        rst_n <= 1;

        // directed: extremes, every mode, error paths
        send_req(MODE_LATEST, 0, 0, 0, 0, 0, 0);
        send_req(MODE_SNAPSHOT, 0, 0, 0, 5, 0, 0);
        send_req(MODE_APPEND, 0, 0, 0, 1, 2, 1);
        send_req(MODE_APPEND, 0, 0, 1, 0, 2, 1);
        send_req(MODE_APPEND, 0, 0, 1, 1, 2, 0);
        send_req(MODE_APPEND, 0, 0, 1, 5, 5, 1);
        send_req(MODE_APPEND, 32'h8000_0000, 32'h7FFF_FFFF, '1, 1, 3, '1);
        send_req(MODE_APPEND, 32'h8000_0000, 32'h7FFF_FFFF, 7, 2, 9, 4);
        send_req(MODE_APPEND, 32'h8000_0000, 32'h7FFF_FFFF, 7, 3, '1 - 1, 4);
        send_req(MODE_APPEND, 32'h8000_0000, 32'h7FFF_FFFF, 7, '1 - 1, '1, 4);
        send_req(MODE_LATEST, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0);
        send_req(MODE_NEXT, 32'h8000_0000, 32'h7FFF_FFFF, 0, '1, 0, 0);
        send_req(MODE_NEXT, 32'h8000_0000, 32'h7FFF_FFFF, 0, 3, 0, 0);
        send_req(MODE_NEXT, 32'h8000_0000, 32'h7FFF_FFFF, 0, 4, 0, 0);
        send_req(MODE_SNAPSHOT, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1, 0, 0);
        send_req(MODE_SNAPSHOT, 32'h8000_0000, 32'h7FFF_FFFF, 0, 2, 0, 0);
        send_req(MODE_SNAPSHOT, 32'h8000_0000, 32'h7FFF_FFFF, 0, '1, 0, 0);
        send_req(MODE_PRUNE, 32'h8000_0000, 32'h7FFF_FFFF, 0, 3, 0, 0);
        send_req(MODE_SNAPSHOT, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1, 0, 0);
        send_req(MODE_PRUNE, 32'h8000_0000, 32'h7FFF_FFFF, 0, '1, 0, 0);
        send_req(3'd7, '1, '1, '1, '1, '1, '1);
        send_req(3'd5, 0, 0, 0, 0, 0, 0);

        // random phases across capacity settings, extremes included
        foreach (key_pool[i]) chain_top[i] = 1;
        write_capacity(7'd0);
        send_req(MODE_PRUNE, 0, 0, 0, '1, 0, 0);
        for (int p = 0; p < 6; p++) begin
            case (p)
                1: write_capacity(7'd1);
                2: write_capacity(7'd127);
                3: write_capacity(7'd5);
                4: write_capacity(7'd64);
                5: write_capacity(7'd17);
                default: ;
            endcase
            for (int i = 0; i < 250; i++) begin
                if (p == 5 && i == 150) calm = 1;
                if (i == 100) wait_empty();
                random_req();
            end
        end

        wait_empty();
        repeat (300) @(negedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
